/* rtl/core/fpmvt_pkg.sv */
// ----------------------------------------------------------------------------
// fpmvt_pkg
// Shared types and constants for the fixed-point matrix-vector transform.
// ----------------------------------------------------------------------------
package fpmvt_pkg;

   localparam int DATA_W   = 32;   // vector and result component width
   localparam int COEF_W   = 16;   // matrix entry width
   localparam int NUM_DIM  = 3;    // rows, columns and vector components
   localparam int ROW_W    = COEF_W * NUM_DIM;
   localparam int PROD_W   = COEF_W + DATA_W;
   localparam int SUM_W    = PROD_W + 2;   // exact sum of three products
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = ROW_W;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_ZERO = 3'd0,
      REG_ROW_ONE  = 3'd1,
      REG_ROW_TWO  = 3'd2,
      REG_OFFSET_X = 3'd3,
      REG_OFFSET_Y = 3'd4,
      REG_OFFSET_Z = 3'd5
   } csr_index_type;

   // identity matrix at reset (1.0 with 12 fraction bits per diagonal entry)
   localparam logic [ROW_W-1:0] ROW_ZERO_RST = 48'h0000_0000_1000;
   localparam logic [ROW_W-1:0] ROW_ONE_RST  = 48'h0000_1000_0000;
   localparam logic [ROW_W-1:0] ROW_TWO_RST  = 48'h1000_0000_0000;

   typedef logic [NUM_DIM-1:0][DATA_W-1:0] vec_type;

   typedef struct packed {
      logic [NUM_DIM-1:0][ROW_W-1:0]  rows;     // index 0 = row_zero
      logic [NUM_DIM-1:0][DATA_W-1:0] offsets;  // index 0 = offset_x
   } cfg_type;

endpackage

/* rtl/core/fpmvt_csr.sv */
// ----------------------------------------------------------------------------
// fpmvt_csr
// Matrix and translation registers, written through a plain write port.
// ----------------------------------------------------------------------------
module fpmvt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [fpmvt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fpmvt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output fpmvt_pkg::cfg_type                  cfg
);

   fpmvt_pkg::cfg_type cfg_ff;
   fpmvt_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            fpmvt_pkg::REG_ROW_ZERO: cfg_in.rows[0] = csr_wdata;
            fpmvt_pkg::REG_ROW_ONE:  cfg_in.rows[1] = csr_wdata;
            fpmvt_pkg::REG_ROW_TWO:  cfg_in.rows[2] = csr_wdata;
            fpmvt_pkg::REG_OFFSET_X: cfg_in.offsets[0] = csr_wdata[fpmvt_pkg::DATA_W-1:0];
            fpmvt_pkg::REG_OFFSET_Y: cfg_in.offsets[1] = csr_wdata[fpmvt_pkg::DATA_W-1:0];
            fpmvt_pkg::REG_OFFSET_Z: cfg_in.offsets[2] = csr_wdata[fpmvt_pkg::DATA_W-1:0];
            default: ;   // unmapped index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows[0]  <= fpmvt_pkg::ROW_ZERO_RST;
         cfg_ff.rows[1]  <= fpmvt_pkg::ROW_ONE_RST;
         cfg_ff.rows[2]  <= fpmvt_pkg::ROW_TWO_RST;
         cfg_ff.offsets  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/fpmvt_row.sv */
// ----------------------------------------------------------------------------
// fpmvt_row
// One result component: row-by-vector dot product, arithmetic shift by the
// fraction width, optional translation, low 32 bits kept.
// ----------------------------------------------------------------------------
module fpmvt_row #(
   parameter int FRAC_BITS = 12
) (
   input  logic [fpmvt_pkg::ROW_W-1:0]   row,
   input  fpmvt_pkg::vec_type            vec,
   input  logic [fpmvt_pkg::DATA_W-1:0]  offset,
   input  logic                          add_offset,
   output logic [fpmvt_pkg::DATA_W-1:0]  result
);

   logic signed [fpmvt_pkg::PROD_W-1:0] prod [fpmvt_pkg::NUM_DIM];
   logic signed [fpmvt_pkg::SUM_W-1:0]  prod_ext [fpmvt_pkg::NUM_DIM];
   logic signed [fpmvt_pkg::SUM_W-1:0]  sum;
   logic signed [fpmvt_pkg::SUM_W-1:0]  shifted;

   // three 16x32 signed products, full width
   for (genvar k = 0; k < fpmvt_pkg::NUM_DIM; k++) begin : g_mul
      assign prod[k] = $signed(row[k*fpmvt_pkg::COEF_W +: fpmvt_pkg::COEF_W])
                     * $signed(vec[k]);
      assign prod_ext[k] = {{(fpmvt_pkg::SUM_W-fpmvt_pkg::PROD_W){prod[k][fpmvt_pkg::PROD_W-1]}},
                            prod[k]};
   end

   assign sum     = prod_ext[0] + prod_ext[1] + prod_ext[2];
   assign shifted = sum >>> FRAC_BITS;   // floor toward minus infinity
   assign result  = shifted[fpmvt_pkg::DATA_W-1:0]
                  + (add_offset ? offset : {fpmvt_pkg::DATA_W{1'b0}});

endmodule

/* rtl/core/fixed_point_matrix_vector_transform.sv */
// ----------------------------------------------------------------------------
// fixed_point_matrix_vector_transform
// 3x3 signed fixed-point matrix times 32-bit vector with optional translation.
// ----------------------------------------------------------------------------
// Pipeline: a req beat passes the input register, then the result register,
//   before rsp_tvalid; the three dot products sit between the two registers.
// Throughput: one vector per cycle; the two-stage pipeline advances whenever
//   the result register is empty or being drained.
// Reset: synchronous, active high; clears both stage valids, loads the
//   identity matrix and zero translation.
// ----------------------------------------------------------------------------
module fixed_point_matrix_vector_transform #(
   parameter int FRAC_BITS = 12   // fraction bits of matrix entries, 0..15
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // input vectors
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [fpmvt_pkg::NUM_DIM*fpmvt_pkg::DATA_W-1:0] req_tdata, // vec_x, vec_y, vec_z
   input  logic                                    req_tuser,  // add_offset
   // results
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [fpmvt_pkg::NUM_DIM*fpmvt_pkg::DATA_W-1:0] rsp_tdata, // out_x, out_y, out_z
   // configuration
   input  logic                                    csr_wen,
   input  logic [fpmvt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [fpmvt_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   fpmvt_pkg::cfg_type cfg;

   // stage 1: registered input beat
   logic                s1_valid_ff, s1_valid_in;
   fpmvt_pkg::vec_type  s1_vec_ff,   s1_vec_in;
   logic                s1_add_ff,   s1_add_in;

   // stage 2: result register
   logic                rsp_valid_ff, rsp_valid_in;
   fpmvt_pkg::vec_type  rsp_data_ff,  rsp_data_in;

   fpmvt_pkg::vec_type  result;
   logic                s2_adv;
   logic                s1_adv;

   fpmvt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // one dot-product unit per matrix row
   for (genvar r = 0; r < fpmvt_pkg::NUM_DIM; r++) begin : g_row
      fpmvt_row #(
         .FRAC_BITS (FRAC_BITS)
      ) u_row (
         .row        (cfg.rows[r]),
         .vec        (s1_vec_ff),
         .offset     (cfg.offsets[r]),
         .add_offset (s1_add_ff),
         .result     (result[r])
      );
   end

   // pipeline control: a stage loads when it is empty or its own item moves on
   assign s2_adv     = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = !s1_valid_ff || s2_adv;
   assign req_tready = s1_adv;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_vec_in    = s1_vec_ff;
      s1_add_in    = s1_add_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s2_adv) begin
         rsp_valid_in = s1_valid_ff;
         rsp_data_in  = result;
      end
      if (s1_adv) begin
         s1_valid_in = req_tvalid;
         s1_vec_in   = req_tdata;
         s1_add_in   = req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_vec_ff   <= s1_vec_in;
      s1_add_ff   <= s1_add_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   // an accepted beat always lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("accepted beat lost at stage 1");

   // stage 1 item moves into the result register when it is free
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (!rsp_tvalid || rsp_tready)) |=> rsp_tvalid)
      else $error("stage 1 item lost on transfer");

   // a full stage 1 behind a stalled result blocks new input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input accepted while pipeline full");

   // a stalled item keeps its data
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_tvalid && !rsp_tready) |=> (s1_valid_ff && $stable(s1_vec_ff)))
      else $error("stage 1 item changed while stalled");
`endif

endmodule

/* tb/sv/fpmvt_scoreboard_pkg.sv */
// ----------------------------------------------------------------------------
// fpmvt_scoreboard_pkg
// Transform predictor and result checker for the matrix-vector transform.
// ----------------------------------------------------------------------------
package fpmvt_scoreboard_pkg;
   import fpmvt_pkg::*;

   class xform_scoreboard #(int FRAC = 12);
      logic [ROW_W-1:0]  rows [NUM_DIM];
      logic [DATA_W-1:0] offsets [NUM_DIM];
      vec_type           expected_outputs [$];
      int unsigned       vectors_in;
      int unsigned       results_out;
      int unsigned       errors;

      function new();
         rows[0] = ROW_ZERO_RST;
         rows[1] = ROW_ONE_RST;
         rows[2] = ROW_TWO_RST;
         foreach (offsets[i]) offsets[i] = '0;
         vectors_in  = 0;
         results_out = 0;
         errors      = 0;
      endfunction

      // bits above a register's width drop out; unmapped indexes do nothing
      function void csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (csr_index_type'(idx))
            REG_ROW_ZERO: rows[0]    = data[ROW_W-1:0];
            REG_ROW_ONE:  rows[1]    = data[ROW_W-1:0];
            REG_ROW_TWO:  rows[2]    = data[ROW_W-1:0];
            REG_OFFSET_X: offsets[0] = data[DATA_W-1:0];
            REG_OFFSET_Y: offsets[1] = data[DATA_W-1:0];
            REG_OFFSET_Z: offsets[2] = data[DATA_W-1:0];
            default: ;
         endcase
      endfunction

      // exact dot product, floor shift, optional translation, low 32 bits
      function vec_type transform_vector(vec_type v, logic add);
         vec_type res;
         longint  acc;
         longint  coef;
         longint  comp;
         for (int r = 0; r < NUM_DIM; r++) begin
            acc = 0;
            for (int c = 0; c < NUM_DIM; c++) begin
               coef = longint'(signed'(rows[r][c*COEF_W +: COEF_W]));
               comp = longint'(signed'(v[c]));
               acc += coef * comp;
            end
            acc    = acc >>> FRAC;
            res[r] = acc[DATA_W-1:0] + (add ? offsets[r] : '0);
         end
         return res;
      endfunction

      function void note_vector(vec_type v, logic add);
         expected_outputs.push_back(transform_vector(v, add));
         vectors_in++;
      endfunction

      function void check_result(vec_type got);
         vec_type want;
         string   names [NUM_DIM] = '{"out_x", "out_y", "out_z"};
         if (expected_outputs.size() == 0) begin
            $error("result beat with nothing expected: %h", got);
            errors++;
            return;
         end
         want = expected_outputs.pop_front();
         results_out++;
         for (int c = 0; c < NUM_DIM; c++) begin
            if (got[c] !== want[c]) begin
               $error("%s mismatch: expected %0d actual %0d",
                      names[c], signed'(want[c]), signed'(got[c]));
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction
   endclass

endpackage

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fixed_point_matrix_vector_transform.
// Loads a series of matrices and translations over the csr port, streams
// directed and random vectors with random gaps and back-pressure, and checks
// every result beat against a predictor built into the scoreboard.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fpmvt_pkg::*;
   import fpmvt_scoreboard_pkg::*;

   localparam int FRAC_BITS  = 12;
   localparam int PIPE_DEPTH = 2;      // req beat to rsp_tvalid
   localparam int IDLE_PCT   = 38;
   localparam int RAND_PHASES = 5;
   localparam int PHASE_BEATS = 130;

   localparam logic [DATA_W-1:0] D_MIN = 32'h8000_0000;
   localparam logic [DATA_W-1:0] D_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] D_NEG1 = 32'hFFFF_FFFF;
   localparam logic [COEF_W-1:0] C_MIN = 16'h8000;
   localparam logic [COEF_W-1:0] C_MAX = 16'h7FFF;
   localparam logic [COEF_W-1:0] C_ONE = 16'h1000;   // 1.0
   localparam logic [COEF_W-1:0] C_NEG_ONE = 16'hF000;
   localparam logic [COEF_W-1:0] C_LSB = 16'h0001;   // 1/4096
   localparam logic [COEF_W-1:0] C_NEG_LSB = 16'hFFFF;

   // indexes past the register map; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [NUM_DIM*DATA_W-1:0] req_tdata = '0;   // vec_x, vec_y, vec_z
   logic                      req_tuser = 1'b0; // add_offset
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [NUM_DIM*DATA_W-1:0] rsp_tdata;        // out_x, out_y, out_z
   logic                      csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   bit idle_on = 1'b1;         // random gaps and stalls on both sides
   int unsigned settings_loaded = 0;

   xform_scoreboard #(FRAC_BITS) sb;

   fixed_point_matrix_vector_transform #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the pipeline hangs.
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Result side: values read here are the ones from before the edge, so a
   // beat counts when both tvalid and tready were high going into it.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         rsp_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   function automatic logic [ROW_W-1:0] pack_row(logic [COEF_W-1:0] c0,
                                                 logic [COEF_W-1:0] c1,
                                                 logic [COEF_W-1:0] c2);
      return {c2, c1, c0};
   endfunction

   // Mix of full-range, small, mid-size and edge values.
   function automatic logic [DATA_W-1:0] pick_component();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 40) return $urandom();
      if (sel < 60) return 32'($urandom_range(8191)) - 32'd4096;
      if (sel < 85) return 32'($urandom_range(2097151)) - 32'd1048576;
      case ($urandom_range(4))
         0: return D_MIN;
         1: return D_MAX;
         2: return '0;
         3: return D_NEG1;
         default: return 32'd1;
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 35) return 16'($urandom());
      if (sel < 70) return 16'($urandom_range(16383)) - 16'd8192;
      case ($urandom_range(4))
         0: return C_MIN;
         1: return C_MAX;
         2: return '0;
         3: return C_ONE;
         default: return C_NEG_ONE;
      endcase
   endfunction

   // One input beat. Valid may drop for random gaps before the item goes out.
   task automatic send_vector(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                              input logic [DATA_W-1:0] z, input logic add);
      vec_type v;
      v = {z, y, x};
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tuser  <= add;
      do @(posedge clock); while (!req_tready);
      sb.note_vector(v, add);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Valid drops first so the last beat is not taken twice. Every vector
   // gives a result, so an empty queue means an empty pipe; the task still
   // waits past that to cover the stages anyway.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.csr_write(idx, data);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_transform(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                                 input logic [ROW_W-1:0] r2, input logic [DATA_W-1:0] ox,
                                 input logic [DATA_W-1:0] oy, input logic [DATA_W-1:0] oz);
      csr_write(REG_ROW_ZERO, r0);
      csr_write(REG_ROW_ONE, r1);
      csr_write(REG_ROW_TWO, r2);
      // junk in the upper bits of offset writes must be dropped
      csr_write(REG_OFFSET_X, {16'($urandom()), ox});
      csr_write(REG_OFFSET_Y, {16'($urandom()), oy});
      csr_write(REG_OFFSET_Z, {16'($urandom()), oz});
      settings_loaded++;
   endtask

   task automatic load_random_transform();
      logic [DATA_W-1:0] ofs [NUM_DIM];
      foreach (ofs[i]) ofs[i] = ($urandom_range(3) == 0) ? pick_component() : $urandom();
      load_transform(pack_row(pick_coef(), pick_coef(), pick_coef()),
                     pack_row(pick_coef(), pick_coef(), pick_coef()),
                     pack_row(pick_coef(), pick_coef(), pick_coef()),
                     ofs[0], ofs[1], ofs[2]);
      // stray writes outside the map; the matrix must not change
      csr_write(CSR_UNMAPPED_LO, CSR_DATA_W'({$urandom(), $urandom()}));
      csr_write(CSR_UNMAPPED_HI, CSR_DATA_W'({$urandom(), $urandom()}));
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed ----
      // identity after reset, zero translation
      send_vector('0, '0, '0, 1'b0);
      send_vector(D_MAX, D_MIN, D_NEG1, 1'b0);
      send_vector(D_MIN, D_MAX, 32'd1, 1'b1);
      drain_results();

      // identity plus extreme translation: result wraps past 32 bits
      load_transform(pack_row(C_ONE, '0, '0), pack_row('0, C_ONE, '0),
                     pack_row('0, '0, C_ONE), D_MAX, D_MIN, 32'd12345);
      send_vector(D_MAX, D_MIN, '0, 1'b1);
      send_vector(D_MAX, D_MIN, '0, 1'b0);
      drain_results();

      // most negative entries against most negative / positive vectors
      load_transform(pack_row(C_MIN, C_MIN, C_MIN), pack_row(C_MIN, C_MIN, C_MIN),
                     pack_row(C_MIN, C_MIN, C_MIN), D_MIN, D_MAX, D_NEG1);
      send_vector(D_MIN, D_MIN, D_MIN, 1'b0);
      send_vector(D_MAX, D_MAX, D_MAX, 1'b0);
      send_vector(D_MIN, D_MAX, D_MIN, 1'b1);
      drain_results();

      // most positive entries, mixed with most negative ones
      load_transform(pack_row(C_MAX, C_MAX, C_MAX), pack_row(C_MAX, C_MIN, C_MAX),
                     pack_row(C_MAX, C_MAX, C_MIN), D_MAX, D_MAX, D_MAX);
      send_vector(D_MAX, D_MAX, D_MAX, 1'b1);
      send_vector(D_MIN, D_MAX, D_MIN, 1'b0);
      drain_results();

      // one-LSB entries and one just under 1.0: the shift must floor toward minus infinity
      load_transform(pack_row(C_LSB, '0, '0), pack_row('0, C_NEG_LSB, '0),
                     pack_row('0, '0, 16'h0FFF), '0, '0, '0);
      send_vector(D_NEG1, D_NEG1, D_NEG1, 1'b0);
      send_vector(32'd4095, 32'd4095, 32'd4095, 1'b0);
      send_vector(-32'sd4097, -32'sd4096, 32'd1, 1'b0);
      send_vector(-32'sd4096, 32'd4097, D_NEG1, 1'b1);
      drain_results();

      // composed transform: columns of a second matrix, then its translation
      load_random_transform();
      send_vector(32'(C_ONE), 32'd2048, '0, 1'b0);
      send_vector(-32'sd512, 32'(C_ONE), 32'd100, 1'b0);
      send_vector('0, -32'sd4096, 32'd8192, 1'b0);
      send_vector(32'd70000, -32'sd300000, 32'd5, 1'b1);
      end_burst();
      drain_results();

      // ---- random phases, new transform each ----
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         load_random_transform();
         idle_on = (ph != 1);   // phase 1 runs at full rate on both sides
         for (int i = 0; i < PHASE_BEATS; i++) begin
            // once, hold off the sender until the pipe is empty
            if (ph == 2 && i == PHASE_BEATS / 2) begin
               end_burst();
               drain_results();
            end
            send_vector(pick_component(), pick_component(), pick_component(),
                        1'($urandom_range(1)));
         end
         end_burst();
         drain_results();
      end
      idle_on = 1'b1;

      // let any stray beat show up before the verdict
      repeat (4 * PIPE_DEPTH) @(posedge clock);

      $display("covered %0d vectors and %0d checked results over %0d loaded transforms",
               sb.vectors_in, sb.results_out, settings_loaded);
      $display("including extreme entries, wrapping translations and floor rounding");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/fpmvt_pkg.sv
rtl/core/fpmvt_csr.sv
rtl/core/fpmvt_row.sv
rtl/core/fixed_point_matrix_vector_transform.sv
tb/sv/fpmvt_scoreboard_pkg.sv
tb/sv/tb.sv
